// ===== hdl/rmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational multiply compare package
// Shared constants, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package rmc_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int PROD_NUM_BITS = 32;
	localparam int PROD_DEN_BITS = 30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD_A,
		ST_DIV_A,
		ST_GCD_B,
		ST_DIV_B,
		ST_MUL,
		ST_GCD_P,
		ST_DIV_P,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic gcd_start_a;
		logic gcd_start_b;
		logic gcd_start_p;
		logic div_start_a;
		logic div_start_b;
		logic div_start_p;
		logic mul;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
	} status_t;

endpackage : rmc_pkg
`default_nettype wire

// ===== hdl/rmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational multiply compare channels
// Valid and ready channels for input and result items.
// ----------------------------------------------------------------------------
interface rmc_in_if #(parameter int OPERAND_BITS = 16);
	logic valid;
	logic ready;
	logic signed [OPERAND_BITS-1:0] a_num;
	logic [OPERAND_BITS-2:0] a_den;
	logic signed [OPERAND_BITS-1:0] b_num;
	logic [OPERAND_BITS-2:0] b_den;
	modport source (output valid, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface : rmc_in_if

interface rmc_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] prod_num;
	logic [29:0] prod_den;
	logic a_less;
	logic a_equal;
	modport source (output valid, prod_num, prod_den, a_less, a_equal, input ready);
	modport sink (input valid, prod_num, prod_den, a_less, a_equal, output ready);
endinterface : rmc_out_if
`default_nettype wire

// ===== hdl/rmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational multiply compare controller
// Sequences the reductions, the multiply and the result transfer.
// ----------------------------------------------------------------------------
module rmc_ctrl
	import rmc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire status_t status,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_GCD_A;
			ST_GCD_A: if (status.gcd_done) state_d = ST_DIV_A;
			ST_DIV_A: if (status.div_done) state_d = ST_GCD_B;
			ST_GCD_B: if (status.gcd_done) state_d = ST_DIV_B;
			ST_DIV_B: if (status.div_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_GCD_P;
			ST_GCD_P: if (status.gcd_done) state_d = ST_DIV_P;
			ST_DIV_P: if (status.div_done) state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.gcd_start_a = in_valid;
			end
			ST_GCD_A: cmd.div_start_a = status.gcd_done;
			ST_DIV_A: cmd.gcd_start_b = status.div_done;
			ST_GCD_B: cmd.div_start_b = status.gcd_done;
			ST_DIV_B: cmd.mul = status.div_done;
			ST_MUL: cmd.gcd_start_p = 1'b1;
			ST_GCD_P: cmd.div_start_p = status.gcd_done;
			ST_DIV_P: cmd.finish = status.div_done;
			ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule : rmc_ctrl
`default_nettype wire

// ===== hdl/rmc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational multiply compare datapath
// Binary gcd unit, shared restoring divider, multiplier and result registers.
// ----------------------------------------------------------------------------
module rmc_datapath
	import rmc_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [OPERAND_BITS-1:0] a_num,
	input wire logic [OPERAND_BITS-2:0] a_den,
	input wire logic signed [OPERAND_BITS-1:0] b_num,
	input wire logic [OPERAND_BITS-2:0] b_den,
	input wire cmd_t cmd,
	output status_t status,
	output logic signed [PROD_NUM_BITS-1:0] prod_num,
	output logic [PROD_DEN_BITS-1:0] prod_den,
	output logic a_less,
	output logic a_equal
);

	localparam int MW = OPERAND_BITS;
	localparam int DW = OPERAND_BITS - 1;
	localparam int PW = 2 * OPERAND_BITS;
	localparam int CW = $clog2(PW + 1);
	localparam int SW = $clog2(PW);

	// Operand registers held as sign and magnitude.
	logic a_neg_q, b_neg_q, p_neg_q;
	logic [MW-1:0] a_mag_q, b_mag_q;
	logic [DW-1:0] a_den_q, b_den_q;
	logic [PW-1:0] p_mag_q, p_den_q;
	logic signed [PW:0] lhs_q, rhs_q;

	logic [MW-1:0] a_mag_in, b_mag_in;
	logic [DW-1:0] a_den_in, b_den_in;

	always_comb begin
		a_mag_in = a_num[MW-1] ? MW'(-a_num) : MW'(a_num);
		b_mag_in = b_num[MW-1] ? MW'(-b_num) : MW'(b_num);
		a_den_in = (a_den == '0) ? DW'(1) : a_den;
		b_den_in = (b_den == '0) ? DW'(1) : b_den;
	end

	// Binary gcd, one step a cycle.
	logic [PW-1:0] gx_q, gy_q;
	logic [SW-1:0] gk_q;
	logic g_busy_q, g_done;
	logic [PW-1:0] g_res;
	logic [PW-1:0] g_val;

	// Divider: divides two dividends by one divisor, one bit a cycle.
	logic [PW-1:0] dq0_q, dq1_q, dr0_q, dr1_q, dd_q;
	logic [CW-1:0] dcnt_q;
	logic d_busy_q, d_done;
	logic [PW:0] dt0, dt1;

	assign g_done = g_busy_q && (gx_q == gy_q || gx_q == '0 || gy_q == '0);
	assign g_res = (gx_q == '0 ? gy_q : gx_q) << gk_q;
	assign g_val = (g_res == '0) ? PW'(1) : g_res;
	assign d_done = d_busy_q && (dcnt_q == '0);
	assign status.gcd_done = g_done;
	assign status.div_done = d_done;

	logic [PW-1:0] p_mag_nx, p_den_nx;
	logic [PW-1:0] g_ld_x, g_ld_y;

	assign p_mag_nx = PW'(a_mag_q) * PW'(b_mag_q);
	assign p_den_nx = PW'(a_den_q) * PW'(b_den_q);

	always_comb begin
		g_ld_x = '0;
		g_ld_y = '0;
		if (cmd.gcd_start_a) begin
			g_ld_x = PW'(a_mag_in);
			g_ld_y = PW'(a_den_in);
		end else if (cmd.gcd_start_b) begin
			g_ld_x = PW'(b_mag_q);
			g_ld_y = PW'(b_den_q);
		end else begin
			g_ld_x = p_mag_nx;
			g_ld_y = p_den_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_busy_q <= 1'b0;
			d_busy_q <= 1'b0;
		end else begin
			if (cmd.gcd_start_a || cmd.gcd_start_b || cmd.gcd_start_p) begin
				g_busy_q <= 1'b1;
			end else if (g_done) begin
				g_busy_q <= 1'b0;
			end
			if (cmd.div_start_a || cmd.div_start_b || cmd.div_start_p) begin
				d_busy_q <= 1'b1;
			end else if (d_done) begin
				d_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gcd_start_a || cmd.gcd_start_b || cmd.gcd_start_p) begin
			gx_q <= g_ld_x;
			gy_q <= g_ld_y;
			gk_q <= '0;
		end else if (g_busy_q && !g_done) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + SW'(1);
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
	end

	assign dt0 = {dr0_q, dq0_q[PW-1]} - {1'b0, dd_q};
	assign dt1 = {dr1_q, dq1_q[PW-1]} - {1'b0, dd_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start_a || cmd.div_start_b || cmd.div_start_p) begin
			dr0_q <= '0;
			dr1_q <= '0;
			dd_q <= g_val;
			dcnt_q <= CW'(PW);
			if (cmd.div_start_a) begin
				dq0_q <= PW'(a_mag_q);
				dq1_q <= PW'(a_den_q);
			end else if (cmd.div_start_b) begin
				dq0_q <= PW'(b_mag_q);
				dq1_q <= PW'(b_den_q);
			end else begin
				dq0_q <= p_mag_q;
				dq1_q <= p_den_q;
			end
		end else if (d_busy_q && !d_done) begin
			dcnt_q <= dcnt_q - CW'(1);
			if (!dt0[PW]) begin
				dr0_q <= dt0[PW-1:0];
				dq0_q <= {dq0_q[PW-2:0], 1'b1};
			end else begin
				dr0_q <= {dr0_q[PW-2:0], dq0_q[PW-1]};
				dq0_q <= {dq0_q[PW-2:0], 1'b0};
			end
			if (!dt1[PW]) begin
				dr1_q <= dt1[PW-1:0];
				dq1_q <= {dq1_q[PW-2:0], 1'b1};
			end else begin
				dr1_q <= {dr1_q[PW-2:0], dq1_q[PW-1]};
				dq1_q <= {dq1_q[PW-2:0], 1'b0};
			end
		end
	end

	logic signed [MW:0] a_sv, b_sv;
	assign a_sv = a_neg_q ? -$signed({1'b0, a_mag_q}) : $signed({1'b0, a_mag_q});
	assign b_sv = b_neg_q ? -$signed({1'b0, b_mag_q}) : $signed({1'b0, b_mag_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_neg_q <= a_num[MW-1];
			b_neg_q <= b_num[MW-1];
			a_mag_q <= a_mag_in;
			b_mag_q <= b_mag_in;
			a_den_q <= a_den_in;
			b_den_q <= b_den_in;
		end
		if (cmd.div_start_b) begin
			a_mag_q <= dq0_q[MW-1:0];
			a_den_q <= (dq0_q == '0) ? DW'(1) : dq1_q[DW-1:0];
			if (dq0_q == '0) a_neg_q <= 1'b0;
		end
		if (cmd.mul) begin
			b_mag_q <= dq0_q[MW-1:0];
			b_den_q <= (dq0_q == '0) ? DW'(1) : dq1_q[DW-1:0];
			if (dq0_q == '0) b_neg_q <= 1'b0;
		end
		if (cmd.gcd_start_p) begin
			p_neg_q <= a_neg_q ^ b_neg_q;
			p_mag_q <= p_mag_nx;
			p_den_q <= p_den_nx;
			lhs_q <= (PW+1)'(a_sv) * $signed({1'b0, b_den_q});
			rhs_q <= $signed({1'b0, a_den_q}) * (PW+1)'(b_sv);
		end
		if (cmd.finish) begin
			prod_num <= (dq0_q == '0 || !p_neg_q) ? PROD_NUM_BITS'(dq0_q)
				: PROD_NUM_BITS'(-dq0_q);
			prod_den <= (dq0_q == '0) ? PROD_DEN_BITS'(1) : PROD_DEN_BITS'(dq1_q);
			a_less <= lhs_q < rhs_q;
			a_equal <= (a_neg_q == b_neg_q) && (a_mag_q == b_mag_q) && (a_den_q == b_den_q);
		end
	end

endmodule : rmc_datapath
`default_nettype wire

// ===== hdl/rational_multiply_compare.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational multiply compare
// Reduces two fractions, multiplies them, reduces the product and compares.
//
// The in channel carries a_num, a_den, b_num and b_den; a transfer happens
// when valid and ready are both high. The out channel carries prod_num,
// prod_den, a_less and a_equal with the same handshake.
// One item is processed at a time, in three binary gcd passes and three
// divider passes between the input transfer and a valid result.
// The next item is taken once the result has been transferred.
// A stalled receiver holds the result on the out channel unchanged.
// Reset returns the controller to idle with no result pending.
// ----------------------------------------------------------------------------
module rational_multiply_compare
	import rmc_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rmc_in_if.sink in_ch,
	rmc_out_if.source out_ch
);

	cmd_t cmd;
	status_t status;

	rmc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	rmc_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.a_num(in_ch.a_num),
		.a_den(in_ch.a_den),
		.b_num(in_ch.b_num),
		.b_den(in_ch.b_den),
		.cmd(cmd),
		.status(status),
		.prod_num(out_ch.prod_num),
		.prod_den(out_ch.prod_den),
		.a_less(out_ch.a_less),
		.a_equal(out_ch.a_equal)
	);

endmodule : rational_multiply_compare
`default_nettype wire
